>>> design/client_table_with_timeout_macros.svh
// Assertion macros used by the checker file.
`ifndef CLIENT_TABLE_WITH_TIMEOUT_MACROS_SVH
`define CLIENT_TABLE_WITH_TIMEOUT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ctt_pkg.sv
package ctt_pkg;

   localparam int unsigned SLOTS_DEF   = 16;
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned QDEPTH      = 2;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned IP_W     = 32;
   localparam int unsigned PORT_W   = 16;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [KIND_W-1:0] KIND_JOIN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEAVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

   localparam logic [CSR_W-1:0] TIMEOUT_RESET = 16'd61;
   localparam logic [CSR_W-1:0] PERIOD_RESET  = 16'd60;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT = 1'b0,
      CSR_PERIOD  = 1'b1
   } ctt_csr_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REFRESHED = 3'd0,
      ST_ADDED     = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_TICK      = 3'd5,
      ST_EXPIRED   = 3'd6
   } ctt_status_type;

   typedef enum logic [1:0] {
      OP_JOIN  = 2'd0,
      OP_LEAVE = 2'd1,
      OP_TICK  = 2'd2,
      OP_SWEEP = 2'd3
   } ctt_op_type;

   typedef enum logic [1:0] {
      BS_IDLE  = 2'd0,
      BS_SCAN  = 2'd1,
      BS_FINAL = 2'd2
   } ctt_bstate_type;

   typedef struct packed {
      ctt_op_type        op;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] now;
   } ctt_cmd_type;

   typedef struct packed {
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] heard;
   } ctt_entry_type;

   typedef struct packed {
      ctt_status_type    status;
      logic [SLOT_W-1:0] slot;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic              last;
   } ctt_res_type;

endpackage

>>> design/ctt_ram.sv
module ctt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ctt_queue.sv
module ctt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  ctt_pkg::ctt_cmd_type push_cmd,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 q_valid,
   output ctt_pkg::ctt_cmd_type q_cmd
);

   import ctt_pkg::*;

   localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

   ctt_cmd_type      entry_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QDEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign push_ready = (count_ff != CNT_W'(QDEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_cmd      = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> design/ctt_front.sv
module ctt_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ctt_pkg::KIND_W-1:0]   req_kind,
   input  logic [ctt_pkg::IP_W-1:0]     req_source_ip,
   input  logic [ctt_pkg::PORT_W-1:0]   req_data_port,
   input  logic [ctt_pkg::CSR_W-1:0]    sweep_period,
   output logic                         push_valid,
   output ctt_pkg::ctt_cmd_type         push_cmd,
   input  logic                         push_ready
);

   import ctt_pkg::*;

   logic [TIME_W-1:0] now_ff, now_in;
   logic [CSR_W-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic [CSR_W-1:0]  cnt_inc;
   logic [CSR_W-1:0]  period_eff;
   logic              sweep_due;
   logic              accept;
   logic              is_tick;

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign is_tick    = (req_kind == KIND_TICK);
   assign cnt_inc    = sweep_cnt_ff + CSR_W'(1);
   // a period of zero behaves as one
   assign period_eff = (sweep_period == '0) ? CSR_W'(1) : sweep_period;
   assign sweep_due  = (cnt_inc >= period_eff);

   always_comb begin
      now_in       = now_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (accept && is_tick) begin
         now_in       = now_ff + TIME_W'(1);
         sweep_cnt_in = sweep_due ? '0 : cnt_inc;
      end
   end

   // classify; the tick carries the advanced time so queued joins keep their own
   always_comb begin
      push_valid    = accept && (req_kind != KIND_NONE);
      push_cmd.ip   = req_source_ip;
      push_cmd.port = req_data_port;
      push_cmd.now  = now_ff;
      push_cmd.op   = OP_JOIN;
      unique case (req_kind)
         KIND_JOIN:  push_cmd.op = OP_JOIN;
         KIND_LEAVE: push_cmd.op = OP_LEAVE;
         KIND_TICK: begin
            push_cmd.op  = sweep_due ? OP_SWEEP : OP_TICK;
            push_cmd.now = now_ff + TIME_W'(1);
         end
         default:    push_cmd.op = OP_JOIN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         sweep_cnt_ff <= '0;
      end else begin
         now_ff       <= now_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

endmodule

>>> design/ctt_back.sv
module ctt_back #(
   parameter int unsigned SLOTS = ctt_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  ctt_pkg::ctt_cmd_type          q_cmd,
   output logic                          pop,
   input  logic [ctt_pkg::CSR_W-1:0]     timeout_seconds,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ctt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ctt_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [ctt_pkg::IP_W-1:0]      rsp_entry_ip,
   output logic [ctt_pkg::PORT_W-1:0]    rsp_entry_port,
   output logic                          rsp_last
);

   import ctt_pkg::*;

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
   localparam int unsigned ENT_W = $bits(ctt_entry_type);

   ctt_bstate_type    state_ff, state_in;
   ctt_cmd_type       cmd_ff, cmd_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]  exp_cnt_ff, exp_cnt_in;
   logic              pend_v_ff, pend_v_in;
   ctt_res_type       pend_ff, pend_in;
   ctt_res_type       res_ff, res_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic              out_valid_ff, out_valid_in;
   ctt_res_type       out_ff, out_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   ctt_entry_type     wr_entry;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_data;
   ctt_entry_type     entry;

   logic              out_free;
   logic              out_push;
   ctt_res_type       push_res;
   logic              cur_valid;
   logic              hit;
   logic              at_end;
   logic [TIME_W-1:0] age;
   logic              expired;
   logic [IDX_W-1:0]  sel_idx;
   ctt_res_type       tick_res;
   ctt_res_type       exp_res;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

   ctt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry     = ctt_entry_type'(rd_data);
   assign out_free  = !out_valid_ff || rsp_ready;
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign hit       = cur_valid && (entry.ip == cmd_ff.ip);
   assign at_end    = (cmp_idx_ff == IDX_W'(SLOTS - 1));
   assign age       = cmd_ff.now - entry.heard;
   assign expired   = cur_valid && (age > {{(TIME_W-CSR_W){1'b0}}, timeout_seconds})
                      && (exp_cnt_ff < CNT_W'(MAX_RESULTS));
   assign sel_idx   = free_found_ff ? free_idx_ff : cmp_idx_ff;

   always_comb begin
      tick_res        = '0;
      tick_res.status = ST_TICK;
      tick_res.last   = 1'b1;
      exp_res.status  = ST_EXPIRED;
      exp_res.slot    = slot_of(cmp_idx_ff);
      exp_res.ip      = entry.ip;
      exp_res.port    = entry.port;
      exp_res.last    = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cmp_idx_in    = cmp_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      exp_cnt_in    = exp_cnt_ff;
      pend_v_in     = pend_v_ff;
      pend_in       = pend_ff;
      res_in        = res_ff;
      valid_in      = valid_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cmp_idx_ff;
      wr_entry      = entry;
      rd_en         = 1'b0;
      rd_addr       = cmp_idx_ff + IDX_W'(1);
      out_push      = 1'b0;
      push_res      = res_ff;

      unique case (state_ff)
         BS_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.op == OP_TICK) begin
                  res_in   = tick_res;
                  state_in = BS_FINAL;
               end else begin
                  rd_en         = 1'b1;
                  rd_addr       = '0;
                  cmp_idx_in    = '0;
                  free_found_in = 1'b0;
                  exp_cnt_in    = '0;
                  pend_v_in     = 1'b0;
                  state_in      = BS_SCAN;
               end
            end
         end

         BS_SCAN: begin
            unique case (cmd_ff.op)
               OP_JOIN: begin
                  if (hit) begin
                     wr_en          = 1'b1;
                     wr_entry.heard = cmd_ff.now;
                     res_in.status  = ST_REFRESHED;
                     res_in.slot    = slot_of(cmp_idx_ff);
                     res_in.ip      = entry.ip;
                     res_in.port    = entry.port;
                     res_in.last    = 1'b1;
                     state_in       = BS_FINAL;
                  end else if (at_end) begin
                     res_in.ip   = cmd_ff.ip;
                     res_in.port = cmd_ff.port;
                     res_in.last = 1'b1;
                     if (free_found_ff || !cur_valid) begin
                        wr_en             = 1'b1;
                        wr_addr           = sel_idx;
                        wr_entry.ip       = cmd_ff.ip;
                        wr_entry.port     = cmd_ff.port;
                        wr_entry.heard    = cmd_ff.now;
                        valid_in[sel_idx] = 1'b1;
                        res_in.status     = ST_ADDED;
                        res_in.slot       = slot_of(sel_idx);
                     end else begin
                        res_in.status = ST_FULL;
                        res_in.slot   = '0;
                     end
                     state_in = BS_FINAL;
                  end else begin
                     if (!cur_valid && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = cmp_idx_ff;
                     end
                     rd_en      = 1'b1;
                     cmp_idx_in = cmp_idx_ff + IDX_W'(1);
                  end
               end

               OP_LEAVE: begin
                  if (hit) begin
                     valid_in[cmp_idx_ff] = 1'b0;
                     res_in.status = ST_REMOVED;
                     res_in.slot   = slot_of(cmp_idx_ff);
                     res_in.ip     = entry.ip;
                     res_in.port   = entry.port;
                     res_in.last   = 1'b1;
                     state_in      = BS_FINAL;
                  end else if (at_end) begin
                     res_in.status = ST_NOT_FOUND;
                     res_in.slot   = '0;
                     res_in.ip     = cmd_ff.ip;
                     res_in.port   = '0;
                     res_in.last   = 1'b1;
                     state_in      = BS_FINAL;
                  end else begin
                     rd_en      = 1'b1;
                     cmp_idx_in = cmp_idx_ff + IDX_W'(1);
                  end
               end

               OP_SWEEP: begin
                  // one expiry is held back until the next is seen, so that
                  // the last flag can be set on the final one
                  if (!(expired && pend_v_ff && !out_free)) begin
                     if (expired) begin
                        valid_in[cmp_idx_ff] = 1'b0;
                        exp_cnt_in = exp_cnt_ff + CNT_W'(1);
                        pend_v_in  = 1'b1;
                        pend_in    = exp_res;
                        if (pend_v_ff) begin
                           out_push = 1'b1;
                           push_res = pend_ff;
                        end
                     end
                     if (at_end) begin
                        if (expired) begin
                           res_in      = exp_res;
                           res_in.last = 1'b1;
                        end else if (pend_v_ff) begin
                           res_in      = pend_ff;
                           res_in.last = 1'b1;
                        end else begin
                           res_in = tick_res;
                        end
                        pend_v_in = 1'b0;
                        state_in  = BS_FINAL;
                     end else begin
                        rd_en      = 1'b1;
                        cmp_idx_in = cmp_idx_ff + IDX_W'(1);
                     end
                  end
               end

               default: begin
                  state_in = BS_IDLE;
               end
            endcase
         end

         BS_FINAL: begin
            if (out_free) begin
               out_push = 1'b1;
               push_res = res_ff;
               state_in = BS_IDLE;
            end
         end

         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (out_push) begin
         out_valid_in = 1'b1;
         out_in       = push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         valid_ff     <= '0;
         pend_v_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_v_ff    <= pend_v_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      exp_cnt_ff    <= exp_cnt_in;
      pend_ff       <= pend_in;
      res_ff        <= res_in;
      out_ff        <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_slot       = out_ff.slot;
   assign rsp_entry_ip   = out_ff.ip;
   assign rsp_entry_port = out_ff.port;
   assign rsp_last       = out_ff.last;

endmodule

>>> design/client_table_with_timeout.sv
// Client session table with aging.
// Request channel (req_valid/req_ready): kind 0 joins or refreshes a client
// by source IP, kind 1 removes it, kind 2 is a one-second tick; kind 3 is
// taken and dropped. Result channel (rsp_valid/rsp_ready) gives one transfer
// per join, leave or plain tick, and on a sweeping tick one transfer per
// expired entry in slot order (rsp_last on the final one), or a single tick
// result when nothing expires.
// Between a request being taken and its final result, a join or leave walks
// the table RAM one slot per cycle and stops at the matching slot, or walks
// every slot on a miss; a sweep always walks every slot; a plain tick skips
// the walk. A full walk holds the back end, which sets the worst sustained
// rate.
// A two-entry command queue lets requests be taken while the walk runs.
// csr_we writes timeout_seconds (index 0) or sweep_period (index 1) at once.
// Reset empties the table and clears the time and sweep counters; no
// clearing pass runs. When rsp_ready is low the result holds and a sweep walk
// may stall; requests keep being taken until the queue fills.
module client_table_with_timeout #(
   parameter int unsigned SLOTS = ctt_pkg::SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ctt_pkg::KIND_W-1:0]      req_kind,
   input  logic [ctt_pkg::IP_W-1:0]        req_source_ip,
   input  logic [ctt_pkg::PORT_W-1:0]      req_data_port,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ctt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ctt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [ctt_pkg::IP_W-1:0]        rsp_entry_ip,
   output logic [ctt_pkg::PORT_W-1:0]      rsp_entry_port,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [ctt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ctt_pkg::CSR_W-1:0]       csr_wdata
);

   import ctt_pkg::*;

   logic [CSR_W-1:0] timeout_ff, timeout_in;
   logic [CSR_W-1:0] period_ff, period_in;
   logic             push_valid;
   logic             push_ready;
   ctt_cmd_type      push_cmd;
   logic             pop;
   logic             q_valid;
   ctt_cmd_type      q_cmd;

   always_comb begin
      timeout_in = timeout_ff;
      period_in  = period_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_wdata;
            CSR_PERIOD:  period_in  = csr_wdata;
            default:     timeout_in = timeout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         period_ff  <= PERIOD_RESET;
      end else begin
         timeout_ff <= timeout_in;
         period_ff  <= period_in;
      end
   end

   ctt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_source_ip (req_source_ip),
      .req_data_port (req_data_port),
      .sweep_period  (period_ff),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd),
      .push_ready    (push_ready)
   );

   ctt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd)
   );

   ctt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .pop             (pop),
      .timeout_seconds (timeout_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_entry_ip    (rsp_entry_ip),
      .rsp_entry_port  (rsp_entry_port),
      .rsp_last        (rsp_last)
   );

endmodule

>>> design/ctt_checker.sv
`include "client_table_with_timeout_macros.svh"

module ctt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ctt_pkg::STATUS_W-1:0]    rsp_status,
   input logic [ctt_pkg::SLOT_W-1:0]      rsp_slot,
   input logic [ctt_pkg::IP_W-1:0]        rsp_entry_ip,
   input logic [ctt_pkg::PORT_W-1:0]      rsp_entry_port,
   input logic                            rsp_last
);

   import ctt_pkg::*;

   // hold a stalled result unchanged
   `CTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_entry_ip) && $stable(rsp_entry_port) && $stable(rsp_last), "stalled result changed")

   // only an expiry may be followed by more results of the same item
   `CTT_ASSERT_NOW(a_single_last, clock, reset, rsp_valid && (rsp_status != ST_EXPIRED), rsp_last, "non-expiry result without last")

   // outcomes that touch no slot report slot zero
   `CTT_ASSERT_NOW(a_no_slot, clock, reset, rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND || rsp_status == ST_TICK), rsp_slot == '0, "slot not zero")

   // a quiet tick carries no entry
   `CTT_ASSERT_NOW(a_tick_empty, clock, reset, rsp_valid && (rsp_status == ST_TICK), rsp_entry_ip == '0 && rsp_entry_port == '0, "tick result carries an entry")

endmodule

bind client_table_with_timeout ctt_checker u_ctt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_slot       (rsp_slot),
   .rsp_entry_ip   (rsp_entry_ip),
   .rsp_entry_port (rsp_entry_port),
   .rsp_last       (rsp_last)
);

>>> verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ctt_pkg::*;

   localparam int unsigned NSLOTS        = SLOTS_DEF;
   localparam int unsigned SETTLE_CYCLES = 60;
   localparam int unsigned PHASE_ITEMS   = 77;
   localparam int unsigned POOL_SIZE     = 20;
   localparam int unsigned REPORT_LIMIT  = 200;

   // Mirror of the session table; queues the results each request must produce.
   class client_session_board;
      bit              used     [NSLOTS];
      bit [IP_W-1:0]   ip_of    [NSLOTS];
      bit [PORT_W-1:0] port_of  [NSLOTS];
      bit [TIME_W-1:0] heard    [NSLOTS];
      bit [TIME_W-1:0] now_secs;
      bit [CSR_W-1:0]  ticks_since_sweep;
      bit [CSR_W-1:0]  timeout_secs;
      bit [CSR_W-1:0]  sweep_ticks;
      ctt_res_type     due_results [$];
      int unsigned     mismatches;

      function new();
         foreach (used[i]) used[i] = 1'b0;
         now_secs          = '0;
         ticks_since_sweep = '0;
         timeout_secs      = TIMEOUT_RESET;
         sweep_ticks       = PERIOD_RESET;
         mismatches        = 0;
      endfunction

      function void write_csr(ctt_csr_type idx, bit [CSR_W-1:0] value);
         case (idx)
            CSR_TIMEOUT: timeout_secs = value;
            CSR_PERIOD:  sweep_ticks  = value;
            default: ;
         endcase
      endfunction

      function void push(ctt_status_type status, int unsigned slot, bit [IP_W-1:0] ip,
                         bit [PORT_W-1:0] port, bit last);
         ctt_res_type r;
         r.status = status;
         r.slot   = SLOT_W'(slot);
         r.ip     = ip;
         r.port   = port;
         r.last   = last;
         due_results.push_back(r);
      endfunction

      function int find_client(bit [IP_W-1:0] ip);
         for (int i = 0; i < NSLOTS; i++)
            if (used[i] && ip_of[i] == ip) return i;
         return -1;
      endfunction

      function void note_request(bit [KIND_W-1:0] kind, bit [IP_W-1:0] ip,
                                 bit [PORT_W-1:0] port);
         int          hit;
         int          free_slot;
         int unsigned victims [$];
         bit [CSR_W-1:0] period;
         hit = find_client(ip);
         case (kind)
            KIND_JOIN: begin
               if (hit >= 0) begin
                  heard[hit] = now_secs;
                  push(ST_REFRESHED, hit, ip_of[hit], port_of[hit], 1'b1);
               end else begin
                  free_slot = -1;
                  for (int i = NSLOTS - 1; i >= 0; i--)
                     if (!used[i]) free_slot = i;
                  if (free_slot < 0) begin
                     push(ST_FULL, 0, ip, port, 1'b1);
                  end else begin
                     used[free_slot]    = 1'b1;
                     ip_of[free_slot]   = ip;
                     port_of[free_slot] = port;
                     heard[free_slot]   = now_secs;
                     push(ST_ADDED, free_slot, ip, port, 1'b1);
                  end
               end
            end
            KIND_LEAVE: begin
               if (hit >= 0) begin
                  used[hit] = 1'b0;
                  push(ST_REMOVED, hit, ip_of[hit], port_of[hit], 1'b1);
               end else begin
                  push(ST_NOT_FOUND, 0, ip, '0, 1'b1);
               end
            end
            KIND_TICK: begin
               period = (sweep_ticks == '0) ? CSR_W'(1) : sweep_ticks;
               now_secs++;
               ticks_since_sweep++;
               if (ticks_since_sweep >= period) begin
                  ticks_since_sweep = '0;
                  // age is taken modulo 2^32; at most MAX_RESULTS drop per sweep
                  for (int i = 0; i < NSLOTS && victims.size() < MAX_RESULTS; i++)
                     if (used[i] && TIME_W'(now_secs - heard[i]) > TIME_W'(timeout_secs))
                        victims.push_back(i);
               end
               if (victims.size() == 0) begin
                  push(ST_TICK, 0, '0, '0, 1'b1);
               end else begin
                  foreach (victims[k]) begin
                     used[victims[k]] = 1'b0;
                     push(ST_EXPIRED, victims[k], ip_of[victims[k]], port_of[victims[k]],
                          k == victims.size() - 1);
                  end
               end
            end
            default: ;  // dropped by the block
         endcase
      endfunction

      function void compare_field(string name, bit [31:0] want, bit [31:0] got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(bit [STATUS_W-1:0] status, bit [SLOT_W-1:0] slot,
                                 bit [IP_W-1:0] ip, bit [PORT_W-1:0] port, bit last);
         ctt_res_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with none expected, actual status %0d slot %0d ip %h port %h last %0b",
                        $time, status, slot, ip, port, last);
            return;
         end
         want = due_results.pop_front();
         compare_field("status", want.status, status);
         compare_field("slot", want.slot, slot);
         compare_field("entry_ip", want.ip, ip);
         compare_field("entry_port", want.port, port);
         compare_field("last", want.last, last);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind = '0;
   logic [IP_W-1:0]      req_source_ip = '0;
   logic [PORT_W-1:0]    req_data_port = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [IP_W-1:0]      rsp_entry_ip;
   logic [PORT_W-1:0]    rsp_entry_port;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   client_session_board board = new();
   int unsigned         send_idle_pct = 0;
   int unsigned         stall_pct = 0;
   bit [IP_W-1:0]       client_pool [POOL_SIZE];
   bit [CSR_W-1:0]      phase_timeout [5] = '{16'd6, 16'hffff, 16'd2, 16'd1, 16'hffff};
   bit [CSR_W-1:0]      phase_period  [5] = '{16'd3, 16'd1, 16'd5, 16'd1, 16'hffff};
   int unsigned         mode_idle  [4] = '{0, 49, 0, 33};
   int unsigned         mode_stall [4] = '{0, 0, 49, 33};

   client_table_with_timeout u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_source_ip  (req_source_ip),
      .req_data_port  (req_data_port),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_entry_ip   (rsp_entry_ip),
      .rsp_entry_port (rsp_entry_port),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_status, rsp_slot, rsp_entry_ip, rsp_entry_port, rsp_last);
   end

   // Entered and left just after a falling edge.
   task automatic send_request(input bit [KIND_W-1:0] kind, input bit [IP_W-1:0] ip,
                               input bit [PORT_W-1:0] port);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_source_ip <= ip;
      req_data_port <= port;
      do @(posedge clock); while (!req_ready);
      board.note_request(kind, ip, port);
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.due_results.size() != 0);
   endtask

   task automatic write_csr(input ctt_csr_type idx, input bit [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      board.write_csr(idx, value);
      @(negedge clock);
   endtask

   task automatic send_random_items(input int unsigned count);
      int unsigned    sent;
      int unsigned    roll;
      bit [KIND_W-1:0] kind;
      bit [IP_W-1:0]  ip;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         if (roll < 45) kind = KIND_JOIN;
         else if (roll < 70) kind = KIND_LEAVE;
         else if (roll < 95) kind = KIND_TICK;
         else kind = KIND_NONE;
         ip = ($urandom_range(9) == 0) ? IP_W'($urandom)
                                       : client_pool[$urandom_range(POOL_SIZE - 1)];
         send_request(kind, ip, PORT_W'($urandom));
         if (kind != KIND_NONE) sent++;
      end
   endtask

   initial begin
      bit [IP_W-1:0] ip;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero timeout, zero period: every tick sweeps, anything older than now drops
      write_csr(CSR_TIMEOUT, '0);
      write_csr(CSR_PERIOD, '0);
      send_request(KIND_JOIN, '0, '0);
      send_request(KIND_JOIN, '1, '1);
      send_request(KIND_JOIN, '0, 16'h1234);
      send_request(KIND_LEAVE, 32'h1234_5678, 16'hbeef);
      send_request(KIND_LEAVE, '0, PORT_W'($urandom));
      send_request(KIND_NONE, IP_W'($urandom), PORT_W'($urandom));
      send_request(KIND_TICK, '0, '0);
      send_request(KIND_TICK, IP_W'($urandom), PORT_W'($urandom));
      // fill every slot, overflow once, then let one sweep expire the lot
      for (int i = 0; i < NSLOTS; i++) begin
         ip = $urandom;
         ip[3:0] = i[3:0];
         send_request(KIND_JOIN, ip, PORT_W'($urandom));
      end
      send_request(KIND_JOIN, IP_W'($urandom), PORT_W'($urandom));
      send_request(KIND_TICK, '0, '0);

      for (int phase = 0; phase < 5; phase++) begin
         wait_results_drained();
         repeat (SETTLE_CYCLES) @(negedge clock);
         write_csr(CSR_TIMEOUT, phase_timeout[phase]);
         write_csr(CSR_PERIOD, phase_period[phase]);
         send_idle_pct = mode_idle[phase % 4];
         stall_pct     = mode_stall[phase % 4];
         foreach (client_pool[k]) client_pool[k] = $urandom;
         send_random_items(PHASE_ITEMS / 2);
         // hold off until the table has answered everything so far
         wait_results_drained();
         send_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
      end

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (board.mismatches == 0 && board.due_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> client_table_with_timeout.f
+incdir+design
design/ctt_pkg.sv
design/ctt_ram.sv
design/ctt_queue.sv
design/ctt_front.sv
design/ctt_back.sv
design/client_table_with_timeout.sv
design/ctt_checker.sv
verif/tb_top.sv
